// ===== rtl/tbap_pkg.sv =====
`default_nettype none
package tbap_pkg;

	localparam int DEFAULT_DEPTH = 256;
	localparam int POS_W         = 9;
	localparam int BTN_W         = 28;
	localparam int PARAM_W       = 32;
	localparam int HAT_W         = 4;
	localparam int DIR_W         = 4;

	typedef enum logic [1:0] {
		KIND_WRITE = 2'd0,
		KIND_START = 2'd1,
		KIND_STOP  = 2'd2,
		KIND_TICK  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		OP_PRESS   = 2'd0,
		OP_RELEASE = 2'd1,
		OP_DELAY   = 2'd2,
		OP_NOP     = 2'd3
	} op_t;

	// direction bit positions inside the 4-bit direction field
	localparam int DIR_DOWN  = 0;
	localparam int DIR_UP    = 1;
	localparam int DIR_LEFT  = 2;
	localparam int DIR_RIGHT = 3;

	localparam logic [HAT_W-1:0] HAT_CENTER     = 4'd0;
	localparam logic [HAT_W-1:0] HAT_UP         = 4'd1;
	localparam logic [HAT_W-1:0] HAT_UP_RIGHT   = 4'd2;
	localparam logic [HAT_W-1:0] HAT_RIGHT      = 4'd3;
	localparam logic [HAT_W-1:0] HAT_DOWN_RIGHT = 4'd4;
	localparam logic [HAT_W-1:0] HAT_DOWN       = 4'd5;
	localparam logic [HAT_W-1:0] HAT_DOWN_LEFT  = 4'd6;
	localparam logic [HAT_W-1:0] HAT_LEFT       = 4'd7;
	localparam logic [HAT_W-1:0] HAT_UP_LEFT    = 4'd8;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_EXEC,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic [7:0]         entry_index;
		logic [1:0]         entry_op;
		logic [PARAM_W-1:0] entry_param;
		logic [POS_W-1:0]   start_count;
	} req_word_t;

	typedef struct packed {
		logic [BTN_W-1:0] buttons;
		logic [HAT_W-1:0] hat;
		logic             playing;
		logic [POS_W-1:0] position;
	} rsp_word_t;

	typedef struct packed {
		logic [1:0]         op;
		logic [PARAM_W-1:0] param;
	} entry_t;

	// result of one program step
	typedef struct packed {
		logic [BTN_W-1:0]   buttons;
		logic [DIR_W-1:0]   dir;
		logic [PARAM_W-1:0] param;
		logic               hold;
		logic               adv;
		logic [POS_W-1:0]   pos;
		logic               more;
	} step_res_t;

	function automatic logic [HAT_W-1:0] hat_code(input logic [DIR_W-1:0] d);
		logic [HAT_W-1:0] h;
		if (d[DIR_UP]) begin
			if (d[DIR_RIGHT])
				h = HAT_UP_RIGHT;
			else if (d[DIR_LEFT])
				h = HAT_UP_LEFT;
			else
				h = HAT_UP;
		end else if (d[DIR_RIGHT]) begin
			h = d[DIR_DOWN] ? HAT_DOWN_RIGHT : HAT_RIGHT;
		end else if (d[DIR_DOWN]) begin
			h = d[DIR_LEFT] ? HAT_DOWN_LEFT : HAT_DOWN;
		end else if (d[DIR_LEFT]) begin
			h = HAT_LEFT;
		end else begin
			h = HAT_CENTER;
		end
		return h;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/timed_button_action_player.sv =====
`default_nettype none
// Flow: write and stop words pass through ST_DONE to the result, start words through ST_LOAD and ST_DONE,
// and a tick walks program entries in ST_EXEC until a delay holds or the program ends, then passes ST_DONE.
// Throughput: one word at a time; the next request is taken once the result word has left,
// so the walk over the program store (one read per entry) sets the per-tick cost.
// Reset: arst_n clears position, length, held buttons, direction bits and current param.
// Program store contents are undefined after reset; no clearing pass is done.
module timed_button_action_player #(
	parameter int PROGRAM_DEPTH = tbap_pkg::DEFAULT_DEPTH
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 req_valid,
	output logic                      req_stall,
	input  wire tbap_pkg::req_word_t  req,
	output logic                      rsp_valid,
	input  wire logic                 rsp_stall,
	output tbap_pkg::rsp_word_t       rsp
);
	import tbap_pkg::*;

	localparam int AW = $clog2(PROGRAM_DEPTH);

	state_t             state_q, state_d;

	// play state
	logic [POS_W-1:0]   pos_q, pos_d;
	logic [POS_W-1:0]   len_q, len_d;
	logic [PARAM_W-1:0] cur_q, cur_d;
	logic [DIR_W-1:0]   dir_q, dir_d;
	logic [BTN_W-1:0]   btn_q, btn_d;
	// set when the store read in flight belongs to a freshly reached entry
	logic               fresh_q, fresh_d;

	logic               out_valid_q;
	rsp_word_t          rsp_q;

	logic               acc;
	logic               wr_en, rd_en;
	logic [AW-1:0]      rd_addr;
	entry_t             wr_data, rd_data;
	logic [PARAM_W-1:0] eff_param;
	step_res_t          stp;
	logic [POS_W-1:0]   sat_len;

	assign acc       = req_valid && !req_stall;
	assign req_stall = (state_q != ST_IDLE) || out_valid_q;
	assign rsp_valid = out_valid_q;
	assign rsp       = rsp_q;

	assign wr_data.op    = req.entry_op;
	assign wr_data.param = req.entry_param;

	// counts beyond the store depth saturate
	assign sat_len = (32'(req.start_count) > PROGRAM_DEPTH) ? POS_W'(PROGRAM_DEPTH)
	                                                        : req.start_count;

	// the param of a newly reached entry comes straight from the store read
	assign eff_param = fresh_q ? rd_data.param : cur_q;

	tbap_store #(
		.DEPTH (PROGRAM_DEPTH),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (AW'(req.entry_index)),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// one program entry per cycle goes through this unit
	tbap_step u_step (
		.op      (rd_data.op),
		.param   (eff_param),
		.pos     (pos_q),
		.len     (len_q),
		.buttons (btn_q),
		.dir     (dir_q),
		.res     (stp)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					case (kind_t'(req.kind))
						KIND_START: state_d = ST_LOAD;
						KIND_TICK:  state_d = (pos_q < len_q) ? ST_EXEC : ST_DONE;
						default:    state_d = ST_DONE;
					endcase
				end
			end
			ST_LOAD: state_d = ST_DONE;
			ST_EXEC: begin
				if (stp.hold || !stp.more)
					state_d = ST_DONE;
			end
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// datapath control
	always_comb begin
		pos_d   = pos_q;
		len_d   = len_q;
		cur_d   = cur_q;
		dir_d   = dir_q;
		btn_d   = btn_q;
		fresh_d = fresh_q;
		wr_en   = 1'b0;
		rd_en   = 1'b0;
		rd_addr = AW'(pos_q);
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					case (kind_t'(req.kind))
						KIND_WRITE: begin
							wr_en = 32'(req.entry_index) < PROGRAM_DEPTH;
						end
						KIND_START: begin
							pos_d   = '0;
							len_d   = sat_len;
							btn_d   = '0;
							dir_d   = '0;
							rd_en   = 1'b1;
							rd_addr = '0;
						end
						KIND_STOP: begin
							pos_d = '0;
							len_d = '0;
							btn_d = '0;
							dir_d = '0;
						end
						default: begin
							fresh_d = 1'b0;
							if (pos_q < len_q) begin
								rd_en = 1'b1;
							end else if (len_q != '0) begin
								pos_d = '0;
								len_d = '0;
								btn_d = '0;
								dir_d = '0;
							end
						end
					endcase
				end
			end
			ST_LOAD: begin
				cur_d = rd_data.param;
			end
			ST_EXEC: begin
				btn_d = stp.buttons;
				dir_d = stp.dir;
				cur_d = stp.param;
				if (stp.adv) begin
					if (stp.more) begin
						pos_d   = stp.pos;
						rd_en   = 1'b1;
						rd_addr = AW'(stp.pos);
						fresh_d = 1'b1;
					end else begin
						// program ran out: playback ends, outputs clear
						pos_d = '0;
						len_d = '0;
						btn_d = '0;
						dir_d = '0;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pos_q   <= '0;
			len_q   <= '0;
			cur_q   <= '0;
			dir_q   <= '0;
			btn_q   <= '0;
			fresh_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pos_q   <= pos_d;
			len_q   <= len_d;
			cur_q   <= cur_d;
			dir_q   <= dir_d;
			btn_q   <= btn_d;
			fresh_q <= fresh_d;
		end
	end

	// result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE) begin
			rsp_q.buttons  <= btn_q;
			rsp_q.hat      <= hat_code(dir_q);
			rsp_q.playing  <= pos_q < len_q;
			rsp_q.position <= pos_q;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/tbap_store.sv =====
`default_nettype none
module tbap_store #(
	parameter int DEPTH = tbap_pkg::DEFAULT_DEPTH,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [AW-1:0]     wr_addr,
	input  wire tbap_pkg::entry_t  wr_data,
	input  wire logic              rd_en,
	input  wire logic [AW-1:0]     rd_addr,
	output tbap_pkg::entry_t       rd_data
);
	import tbap_pkg::*;

	entry_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (rd_en)
			rd_data <= mem_q[rd_addr];
	end

endmodule
`default_nettype wire

// ===== rtl/tbap_step.sv =====
`default_nettype none
module tbap_step (
	input  wire logic [1:0]                   op,
	input  wire logic [tbap_pkg::PARAM_W-1:0] param,
	input  wire logic [tbap_pkg::POS_W-1:0]   pos,
	input  wire logic [tbap_pkg::POS_W-1:0]   len,
	input  wire logic [tbap_pkg::BTN_W-1:0]   buttons,
	input  wire logic [tbap_pkg::DIR_W-1:0]   dir,
	output tbap_pkg::step_res_t               res
);
	import tbap_pkg::*;

	logic [DIR_W-1:0] dir_sel;

	assign dir_sel = param[PARAM_W-1 -: DIR_W];

	always_comb begin
		res         = '0;
		res.buttons = buttons;
		res.dir     = dir;
		res.param   = param;
		res.pos     = pos + POS_W'(1);
		res.more    = res.pos < len;
		case (op)
			OP_PRESS: begin
				res.adv = 1'b1;
				if (dir_sel != '0)
					res.dir = dir | dir_sel;
				else
					res.buttons = buttons | param[BTN_W-1:0];
			end
			OP_RELEASE: begin
				res.adv = 1'b1;
				if (dir_sel != '0)
					res.dir = dir & ~dir_sel;
				else
					res.buttons = buttons & ~param[BTN_W-1:0];
			end
			OP_DELAY: begin
				if (param == '0) begin
					res.adv = 1'b1;
				end else begin
					res.hold  = 1'b1;
					res.param = param - PARAM_W'(1);
				end
			end
			default: begin
				res.adv = 1'b1;
			end
		endcase
	end

endmodule
`default_nettype wire
